[sv/assert_macros.svh]
// Assertion macros shared by the point-in-polygon RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset
`define PIP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every clock edge, reset included
`define PIP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[sv/pip_pkg.sv]
// Shared types and constants of the point-in-polygon tester
`default_nettype none
package pip_pkg;
    localparam int CoordW         = 16;
    localparam int CountW         = 5;
    localparam int IndexW         = 4;
    localparam int MaxVerticesDef = 16;
    localparam int DiffW          = CoordW + 1;
    localparam int NumW           = 2 * DiffW + 1;
    localparam int ProdW          = 2 * (DiffW + 1);

    localparam logic KindWrite = 1'b0;
    localparam logic KindQuery = 1'b1;

    localparam logic [1:0] DrainLast = 2'd2;

    typedef logic signed [CoordW-1:0] coord_t;

    typedef struct packed {
        logic   valid;
        coord_t xi;
        coord_t yi;
        coord_t xj;
        coord_t yj;
        coord_t px;
        coord_t py;
    } edge_req_t;

    typedef struct packed {
        logic valid;
        logic hit;
    } edge_rsp_t;
endpackage
`default_nettype wire

[sv/pip_cell.sv]
// One vertex cell of the rotating vertex ring
`default_nettype none
module pip_cell (
    input  wire logic            aclk,
    input  wire logic            load,
    input  wire logic            shift,
    input  wire pip_pkg::coord_t load_x,
    input  wire pip_pkg::coord_t load_y,
    input  wire pip_pkg::coord_t nb_x,
    input  wire pip_pkg::coord_t nb_y,
    output pip_pkg::coord_t      x_out,
    output pip_pkg::coord_t      y_out
);
    import pip_pkg::*;

    coord_t x_reg, y_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            x_reg <= load_x;
            y_reg <= load_y;
        end else if (shift) begin
            x_reg <= nb_x;
            y_reg <= nb_y;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
endmodule
`default_nettype wire

[sv/pip_edge.sv]
// Pipelined crossing test of one polygon edge against the query point
`default_nettype none
`include "assert_macros.svh"
module pip_edge (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire pip_pkg::edge_req_t req,
    output pip_pkg::edge_rsp_t      rsp
);
    import pip_pkg::*;

    logic                    a_valid_reg, b_valid_reg, c_valid_reg;
    logic                    a_str_reg, b_str_reg, c_str_reg;
    logic signed [DiffW-1:0] a_dx_reg, a_dy_reg, a_den_reg, a_d_reg;
    logic signed [DiffW-1:0] b_den_reg, b_d_reg;
    logic signed [2*DiffW-1:0] b_num_reg;
    logic signed [NumW-1:0]  c_num_reg;
    logic signed [ProdW-1:0] c_m_reg;

    logic                    a_str_next;
    logic signed [NumW-1:0]  num_next;
    logic signed [DiffW:0]   den_pos, fac;
    logic signed [ProdW-1:0] m_next;
    logic signed [ProdW:0]   m_ext, n_ext;

    always_comb begin
        a_str_next = (req.yi > req.py) != (req.yj > req.py);
        if (b_den_reg < 0) begin
            num_next = -NumW'(b_num_reg);
            den_pos  = -(DiffW+1)'(b_den_reg);
        end else begin
            num_next = NumW'(b_num_reg);
            den_pos  = (DiffW+1)'(b_den_reg);
        end
        fac    = (num_next >= 0) ? (DiffW+1)'(b_d_reg) + (DiffW+1)'(1)
                                 : (DiffW+1)'(b_d_reg);
        m_next = fac * den_pos;
        m_ext  = (ProdW+1)'(c_m_reg);
        n_ext  = (ProdW+1)'(c_num_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= req.valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
        a_str_reg <= a_str_next;
        a_dx_reg  <= DiffW'(req.xj) - DiffW'(req.xi);
        a_dy_reg  <= DiffW'(req.py) - DiffW'(req.yi);
        a_den_reg <= DiffW'(req.yj) - DiffW'(req.yi);
        a_d_reg   <= DiffW'(req.px) - DiffW'(req.xi);
        b_str_reg <= a_str_reg;
        b_num_reg <= a_dx_reg * a_dy_reg;
        b_den_reg <= a_den_reg;
        b_d_reg   <= a_d_reg;
        c_str_reg <= b_str_reg;
        c_num_reg <= num_next;
        c_m_reg   <= m_next;
    end

    assign rsp.valid = c_valid_reg;
    assign rsp.hit   = c_str_reg && ((c_num_reg >= 0) ? (m_ext <= n_ext) : (m_ext < n_ext));

    `PIP_ASSERT(a_follows_req, a_valid_reg |-> $past(req.valid), "stage A without request")
    `PIP_ASSERT(c_follows_b, c_valid_reg |-> $past(b_valid_reg), "stage C without stage B")
endmodule
`default_nettype wire

[sv/point_in_polygon_test.sv]
// Top level of the crossing-number point-in-polygon tester
// A vertex write is accepted only while idle. A query runs ST_RUN, in which
// the vertex ring rotates once through all MAX_VERTICES cells, one edge
// entering the three-stage crossing pipeline per cycle with the closing edge
// last, then ST_DRAIN empties the pipeline and ST_FIN loads the result. Only
// one query is in flight; an unread result in the output register holds the
// next query in ST_FIN until m_ready is high.
`default_nettype none
`include "assert_macros.svh"
module point_in_polygon_test #(
    parameter int MAX_VERTICES = pip_pkg::MaxVerticesDef
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_we,
    input  wire logic [pip_pkg::CountW-1:0] cfg_wdata,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic                       s_kind,
    input  wire logic [pip_pkg::IndexW-1:0] s_vertex_index,
    input  wire pip_pkg::coord_t            s_x_coord,
    input  wire pip_pkg::coord_t            s_y_coord,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic                            m_inside_res
);
    import pip_pkg::*;

    localparam int StepW = $clog2(MAX_VERTICES + 1);
    localparam int CmpW  = (StepW > CountW) ? StepW : CountW;
    localparam logic [StepW-1:0] StepLast = StepW'(MAX_VERTICES);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_FIN} state_t;

    state_t            state_reg, state_next;
    logic [StepW-1:0]  step_reg, step_next, n_reg, n_next;
    logic [1:0]        drain_reg, drain_next;
    logic [CountW-1:0] count_reg, count_next;
    logic              parity_reg, parity_next;
    logic              m_valid_reg, m_valid_next, m_inside_reg, m_inside_next;
    coord_t            px_reg, py_reg, prev_x_reg, prev_y_reg, v0x_reg, v0y_reg;
    coord_t            px_next, py_next, prev_x_next, prev_y_next, v0x_next, v0y_next;

    coord_t    cell_x [MAX_VERTICES];
    coord_t    cell_y [MAX_VERTICES];
    logic      in_fire, wr_fire, shift;
    edge_req_t req;
    edge_rsp_t rsp;

    assign s_ready = (state_reg == ST_IDLE);
    assign in_fire = s_valid && s_ready;
    assign wr_fire = in_fire && (s_kind == KindWrite);
    assign shift   = (state_reg == ST_RUN) && (step_reg != StepLast);

    for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_ring
        pip_cell u_cell (
            .aclk   (aclk),
            .load   (wr_fire && (32'(s_vertex_index) == k)),
            .shift  (shift),
            .load_x (s_x_coord),
            .load_y (s_y_coord),
            .nb_x   (cell_x[(k + 1) % MAX_VERTICES]),
            .nb_y   (cell_y[(k + 1) % MAX_VERTICES]),
            .x_out  (cell_x[k]),
            .y_out  (cell_y[k])
        );
    end

    always_comb begin
        req.valid = (state_reg == ST_RUN) && (step_reg != '0) && (step_reg <= n_reg);
        req.xi    = (step_reg == n_reg) ? v0x_reg : cell_x[0];
        req.yi    = (step_reg == n_reg) ? v0y_reg : cell_y[0];
        req.xj    = prev_x_reg;
        req.yj    = prev_y_reg;
        req.px    = px_reg;
        req.py    = py_reg;
    end

    pip_edge u_edge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        n_next        = n_reg;
        drain_next    = drain_reg;
        count_next    = cfg_we ? cfg_wdata : count_reg;
        parity_next   = parity_reg ^ (rsp.valid && rsp.hit);
        m_valid_next  = m_valid_reg && !m_ready;
        m_inside_next = m_inside_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        prev_x_next   = prev_x_reg;
        prev_y_next   = prev_y_reg;
        v0x_next      = v0x_reg;
        v0y_next      = v0y_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire && (s_kind == KindQuery)) begin
                    state_next  = ST_RUN;
                    step_next   = '0;
                    parity_next = 1'b0;
                    px_next     = s_x_coord;
                    py_next     = s_y_coord;
                    if (CmpW'(count_reg) > CmpW'(MAX_VERTICES)) n_next = StepLast;
                    else n_next = StepW'(count_reg);
                end
            end
            ST_RUN: begin
                prev_x_next = cell_x[0];
                prev_y_next = cell_y[0];
                if (step_reg == '0) begin
                    v0x_next = cell_x[0];
                    v0y_next = cell_y[0];
                end
                if (step_reg == StepLast) begin
                    state_next = ST_DRAIN;
                    drain_next = '0;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == DrainLast) state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_inside_next = parity_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            drain_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            drain_reg   <= drain_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        n_reg        <= n_next;
        parity_reg   <= parity_next;
        m_inside_reg <= m_inside_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
        prev_x_reg   <= prev_x_next;
        prev_y_reg   <= prev_y_next;
        v0x_reg      <= v0x_next;
        v0y_reg      <= v0y_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_inside_res = m_inside_reg;

    `PIP_ASSERT(edge_only_in_run, req.valid |-> (state_reg == ST_RUN), "edge issued outside run")
    `PIP_ASSERT(step_bounded, (state_reg == ST_RUN) |-> (step_reg <= StepLast), "step overrun")
    `PIP_ASSERT(fin_loads_result, ($past(state_reg) == ST_FIN && state_reg == ST_IDLE) |-> m_valid, "result lost")
    `PIP_ASSERT(pipe_empty_at_fin, (state_reg == ST_FIN) |-> !rsp.valid, "edge still in flight")
endmodule
`default_nettype wire
